[src/proximity_baseline_tracker_top_assert.svh]
// Assertion macros for the proximity baseline tracker checker.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef PROXIMITY_BASELINE_TRACKER_TOP_ASSERT_SVH
`define PROXIMITY_BASELINE_TRACKER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PBT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/pbt_pkg.sv]
// Shared constants, types and the blend function of the proximity baseline tracker.
// No dependencies; every other file but the assertion header uses it by scoped names.
package pbt_pkg;

   // Fixed-point format of all tracked values
   localparam int FracBits = 8;
   localparam int IntBits  = 15;
   localparam int ValW     = IntBits + FracBits;

   // Field and register widths
   localparam int CountW   = 15;
   localparam int WeightW  = 9;
   localparam int EpsW     = 8;
   localparam int CntW     = 8;
   localparam int DutyW    = 8;
   localparam int GazeW    = 4;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 9;

   // Weights are in units of 1/256
   localparam int WeightShift = 8;
   localparam logic [WeightW-1:0] FullWeight = WeightW'(1 << WeightShift);

   // Mapping window 4..20 spans 16 counts, so the divide is a shift
   localparam int DeltaLow  = 4;
   localparam int DeltaHigh = 20;
   localparam int MapShift  = $clog2(DeltaHigh - DeltaLow);
   localparam int DutyTop   = 255;
   localparam int GazeTop   = 8;
   localparam int GazeShift = $clog2(GazeTop);

   localparam logic [CntW-1:0] CountTop = {CntW{1'b1}};

   // Register indexes
   localparam logic [CsrIdxW-1:0] CsrFreqWeight  = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CsrDeltaWeight = CsrIdxW'(1);
   localparam logic [CsrIdxW-1:0] CsrEpsilon     = CsrIdxW'(2);
   localparam logic [CsrIdxW-1:0] CsrTarget      = CsrIdxW'(3);
   localparam logic [CsrIdxW-1:0] CsrAutoBase    = CsrIdxW'(4);

   typedef logic [ValW-1:0] val_type;

   localparam val_type DeltaLimit = val_type'(DeltaLow) << FracBits;

   typedef struct packed {
      logic [WeightW-1:0] freq_weight;
      logic [WeightW-1:0] delta_weight;
      logic [EpsW-1:0]    stable_epsilon;
      logic [CntW-1:0]    stable_target;
      logic               auto_base_enable;
   } cfg_type;

   // Weighted average (w*fresh + (256-w)*old) >> 8, weight clamped to 256
   function automatic val_type blend(logic [WeightW-1:0] w, val_type fresh, val_type old);
      logic [WeightW-1:0]    wt;
      logic [ValW+WeightW-1:0] p_new;
      logic [ValW+WeightW-1:0] p_old;
      logic [ValW+WeightW:0]   sum;
      wt    = (w > FullWeight) ? FullWeight : w;
      p_new = {{ValW{1'b0}}, wt} * {{WeightW{1'b0}}, fresh};
      p_old = {{ValW{1'b0}}, FullWeight - wt} * {{WeightW{1'b0}}, old};
      sum   = {1'b0, p_new} + {1'b0, p_old};
      return sum[ValW+WeightShift-1:WeightShift];
   endfunction

endpackage

[src/pbt_ifs.sv]
// Valid/ready channel interfaces for the tracker's input and result items.
// Depends on pbt_pkg for field widths.
interface pbt_req_if;
   logic                         valid;
   logic                         ready;
   logic [pbt_pkg::CountW-1:0]   sample_count;
   logic                         set_base;

   modport source (output valid, output sample_count, output set_base, input ready);
   modport sink   (input valid, input sample_count, input set_base, output ready);
endinterface

interface pbt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pbt_pkg::DutyW-1:0]    duty;
   logic [pbt_pkg::GazeW-1:0]    gaze_index;
   logic                         stable;

   modport source (output valid, output duty, output gaze_index, output stable, input ready);
   modport sink   (input valid, input duty, input gaze_index, input stable, output ready);
endinterface

[src/proximity_baseline_tracker_top.sv]
// Proximity baseline tracker: takes one pulse count per item and returns one
// duty/gaze/stable result per item. The block accepts an item in every cycle
// while not stalled. The input register loads at the accepting edge; the
// frequency average, the stability and delta average, and the output mapping
// then each take one register step. The whole pipeline advances together and
// stalls only when a result is held at the output and the consumer is not
// ready. Configuration writes take effect on the next cycle; the user must
// see that they are made while idle, as the block does not enforce it.
// Depends on pbt_pkg, pbt_ifs, pbt_csr and pbt_map.
module proximity_baseline_tracker_top (
   input  logic                          clock,
   input  logic                          reset,
   pbt_req_if.sink                       req_ch,
   pbt_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [pbt_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [pbt_pkg::CsrDataW-1:0]  csr_wdata
);

   pbt_pkg::cfg_type cfg;

   logic advance;

   // Input register
   logic                          s0_valid_ff;
   logic [pbt_pkg::CountW-1:0]    s0_count_ff;
   logic                          s0_set_base_ff;

   // Frequency average step
   logic                          s1_valid_ff;
   logic                          s1_set_base_ff;
   pbt_pkg::val_type              freq_ff;
   pbt_pkg::val_type              freq_in;
   pbt_pkg::val_type              prev_ff;

   // Stability and delta step
   logic                          s2_valid_ff;
   logic                          s2_stable_ff;
   logic                          stable_in;
   pbt_pkg::val_type              delta_ff;
   pbt_pkg::val_type              delta_in;
   pbt_pkg::val_type              base_ff;
   pbt_pkg::val_type              base_in;
   pbt_pkg::val_type              drop;
   pbt_pkg::val_type              change;
   pbt_pkg::val_type              eps_val;
   logic [pbt_pkg::CntW-1:0]      cnt_ff;
   logic [pbt_pkg::CntW-1:0]      cnt_in;
   logic [pbt_pkg::CntW-1:0]      cnt_inc;

   // Output register
   logic                          rsp_valid_ff;
   logic [pbt_pkg::DutyW-1:0]     duty_ff;
   logic [pbt_pkg::GazeW-1:0]     gaze_ff;
   logic                          rsp_stable_ff;
   logic [pbt_pkg::DutyW-1:0]     duty_in;
   logic [pbt_pkg::GazeW-1:0]     gaze_in;

   pbt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pbt_map u_map (
      .smoothed_delta (delta_ff),
      .duty           (duty_in),
      .gaze_index     (gaze_in)
   );

   // Advance the pipeline unless a result is held and not taken
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // Frequency average of the new count
   assign freq_in = pbt_pkg::blend(cfg.freq_weight,
                                   {s0_count_ff, {pbt_pkg::FracBits{1'b0}}}, freq_ff);

   // Stability counter, baseline refresh and delta average
   always_comb begin
      change    = (freq_ff >= prev_ff) ? freq_ff - prev_ff : prev_ff - freq_ff;
      eps_val   = pbt_pkg::val_type'({cfg.stable_epsilon, {pbt_pkg::FracBits{1'b0}}});
      cnt_inc   = (cnt_ff == pbt_pkg::CountTop) ? cnt_ff : cnt_ff + 1'b1;
      stable_in = 1'b0;
      cnt_in    = '0;
      if (delta_ff < pbt_pkg::DeltaLimit && change < eps_val) begin
         cnt_in    = cnt_inc;
         stable_in = (cnt_inc >= cfg.stable_target);
      end
      base_in = base_ff;
      if (s1_set_base_ff) begin
         base_in = freq_ff;
         cnt_in  = '0;
      end
      if (stable_in && cfg.auto_base_enable) begin
         base_in = freq_ff;
      end
      drop     = (base_in > freq_ff) ? base_in - freq_ff : '0;
      delta_in = pbt_pkg::blend(cfg.delta_weight, drop, delta_ff);
   end

   // Control: valid bits of every step
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= req_ch.valid;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Tracking state: updated once per item in its own step
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff  <= '0;
         prev_ff  <= '0;
         delta_ff <= '0;
         base_ff  <= '0;
         cnt_ff   <= '0;
      end else if (advance) begin
         if (s0_valid_ff) begin
            freq_ff <= freq_in;
            prev_ff <= freq_ff;
         end
         if (s1_valid_ff) begin
            delta_ff <= delta_in;
            base_ff  <= base_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         if (req_ch.valid) begin
            s0_count_ff    <= req_ch.sample_count;
            s0_set_base_ff <= req_ch.set_base;
         end
         if (s0_valid_ff) begin
            s1_set_base_ff <= s0_set_base_ff;
         end
         if (s1_valid_ff) begin
            s2_stable_ff <= stable_in;
         end
         if (s2_valid_ff) begin
            duty_ff       <= duty_in;
            gaze_ff       <= gaze_in;
            rsp_stable_ff <= s2_stable_ff;
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.duty       = duty_ff;
   assign rsp_ch.gaze_index = gaze_ff;
   assign rsp_ch.stable     = rsp_stable_ff;

endmodule

[src/pbt_csr.sv]
// Configuration register file of the proximity baseline tracker.
// Depends on pbt_pkg for register indexes and the cfg_type struct.
module pbt_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [pbt_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [pbt_pkg::CsrDataW-1:0]  csr_wdata,
   output pbt_pkg::cfg_type              cfg
);

   pbt_pkg::cfg_type cfg_ff;
   pbt_pkg::cfg_type cfg_in;

   // Decode one register write; unlisted indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pbt_pkg::CsrFreqWeight:  cfg_in.freq_weight      = csr_wdata;
            pbt_pkg::CsrDeltaWeight: cfg_in.delta_weight     = csr_wdata;
            pbt_pkg::CsrEpsilon:     cfg_in.stable_epsilon   = csr_wdata[pbt_pkg::EpsW-1:0];
            pbt_pkg::CsrTarget:      cfg_in.stable_target    = csr_wdata[pbt_pkg::CntW-1:0];
            pbt_pkg::CsrAutoBase:    cfg_in.auto_base_enable = csr_wdata[0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.freq_weight      <= pbt_pkg::WeightW'(128);
         cfg_ff.delta_weight     <= pbt_pkg::WeightW'(154);
         cfg_ff.stable_epsilon   <= pbt_pkg::EpsW'(3);
         cfg_ff.stable_target    <= pbt_pkg::CntW'(10);
         cfg_ff.auto_base_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/pbt_map.sv]
// Maps the smoothed delta to a drive duty and a gaze index.
// Depends on pbt_pkg for the mapping window and field widths.
module pbt_map (
   input  pbt_pkg::val_type              smoothed_delta,
   output logic [pbt_pkg::DutyW-1:0]     duty,
   output logic [pbt_pkg::GazeW-1:0]     gaze_index
);

   localparam int DW = pbt_pkg::IntBits;

   logic [DW-1:0]                     d;
   logic [DW-1:0]                     e;
   logic [DW+pbt_pkg::DutyW-1:0]      scaled;
   logic [DW+pbt_pkg::DutyW-1:0]      dv;
   logic [DW+pbt_pkg::GazeShift-1:0]  gv;

   // Integer part, offset from the bottom of the window
   assign d      = smoothed_delta[pbt_pkg::ValW-1:pbt_pkg::FracBits];
   assign e      = d - DW'(pbt_pkg::DeltaLow);
   // e*255 as e*256 - e, then divide by the window width
   assign scaled = {e, {pbt_pkg::DutyW{1'b0}}} - {{pbt_pkg::DutyW{1'b0}}, e};
   assign dv     = scaled >> pbt_pkg::MapShift;
   assign gv     = {e, {pbt_pkg::GazeShift{1'b0}}} >> pbt_pkg::MapShift;

   // Clamp both outputs; below the window the block is at rest
   always_comb begin
      if (d < DW'(pbt_pkg::DeltaLow)) begin
         duty       = '0;
         gaze_index = pbt_pkg::GazeW'(pbt_pkg::GazeTop);
      end else begin
         duty = (dv > (DW+pbt_pkg::DutyW)'(pbt_pkg::DutyTop)) ?
                pbt_pkg::DutyW'(pbt_pkg::DutyTop) : dv[pbt_pkg::DutyW-1:0];
         gaze_index = (gv >= (DW+pbt_pkg::GazeShift)'(pbt_pkg::GazeTop)) ? '0 :
                      pbt_pkg::GazeW'(pbt_pkg::GazeTop) - gv[pbt_pkg::GazeW-1:0];
      end
   end

endmodule

[src/pbt_checker.sv]
// Port-level checker for the proximity baseline tracker, bound to the top level.
// Depends on pbt_pkg and the macros in proximity_baseline_tracker_top_assert.svh.
`include "proximity_baseline_tracker_top_assert.svh"

module pbt_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_ready,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [pbt_pkg::DutyW-1:0]   rsp_duty,
   input  logic [pbt_pkg::GazeW-1:0]   rsp_gaze_index
);

   // A stalled result stays offered
   `PBT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // An empty output never blocks the input side
   `PBT_ASSERT_NOW(a_req_open, !rsp_valid, req_ready, "input stalled with empty output")

   // Gaze stays within its range
   `PBT_ASSERT_NOW(a_gaze_range, rsp_valid, rsp_gaze_index <= pbt_pkg::GazeW'(pbt_pkg::GazeTop), "gaze index out of range")

   // Resting gaze only with a low duty
   `PBT_ASSERT_NOW(a_rest_duty, rsp_valid && rsp_gaze_index == pbt_pkg::GazeW'(pbt_pkg::GazeTop), rsp_duty <= pbt_pkg::DutyW'(15), "duty high at resting gaze")

   // Fully turned gaze only at full duty
   `PBT_ASSERT_NOW(a_full_duty, rsp_valid && rsp_gaze_index == '0, rsp_duty == pbt_pkg::DutyW'(pbt_pkg::DutyTop), "duty not full at zero gaze")

endmodule

bind proximity_baseline_tracker_top pbt_checker u_pbt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_duty       (rsp_ch.duty),
   .rsp_gaze_index (rsp_ch.gaze_index)
);
